>>> rtl/core/preamble_packet_parser_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the preamble packet parser
// Shared property wrappers, sampled on clk with arst_n low masking the check.
// ---------------------------------------------------------------------------
`ifndef PREAMBLE_PACKET_PARSER_CORE_DEFINES_SVH
`define PREAMBLE_PACKET_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define PPP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppp same-cycle check failed");

// Next-cycle implication.
`define PPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppp next-cycle check failed");

`endif

>>> rtl/core/ppp_pkg.sv
// ---------------------------------------------------------------------------
// Preamble packet parser package
// Framing constants, status codes and the result record.
// ---------------------------------------------------------------------------
package ppp_pkg;

	localparam int HEADER_BYTES = 5;

	localparam logic [7:0] HEADER_LEN = 8'(HEADER_BYTES);
	localparam logic [7:0] MIN_LENGTH = 8'(HEADER_BYTES + 1);

	localparam logic [7:0] PRE1 = 8'h03;
	localparam logic [7:0] PRE2 = 8'hAF;
	localparam logic [7:0] PRE3 = 8'hEF;

	typedef enum logic [2:0] {
		ST_NONE = 3'd0,
		ST_OK   = 3'd1,
		ST_PRE1 = 3'd2,
		ST_PRE2 = 3'd3,
		ST_PRE3 = 3'd4,
		ST_LEN  = 3'd5,
		ST_SUM  = 3'd6
	} status_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       packet_last;
		status_t    status;
	} result_t;

endpackage

>>> rtl/core/ppp_in_stage.sv
// ---------------------------------------------------------------------------
// Input register
// Captures one received byte; frees up when the parse stage takes it.
// ---------------------------------------------------------------------------
module ppp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       take,      // parse stage consumes the held byte
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

>>> rtl/core/ppp_parse.sv
// ---------------------------------------------------------------------------
// Packet parse step
// Framing state machine with running XOR and payload counters.
// ---------------------------------------------------------------------------
module ppp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,     // byte consumed this cycle
	input  logic [7:0]        byte_in,
	output ppp_pkg::result_t  result
);

	typedef enum logic [2:0] {
		PH_PRE1 = 3'd0,
		PH_PRE2 = 3'd1,
		PH_PRE3 = 3'd2,
		PH_SUM  = 3'd3,
		PH_LEN  = 3'd4,
		PH_DATA = 3'd5,
		PH_HUNT = 3'd6
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] xor_q, xor_n;
	logic [7:0] count_q, count_n;
	logic [7:0] pos_q, pos_n;

	always_comb begin
		phase_n = phase_q;
		xor_n   = xor_q ^ byte_in;
		count_n = count_q;
		pos_n   = pos_q;
		result  = '0;
		result.status = ppp_pkg::ST_NONE;

		case (phase_q)
			PH_PRE1: begin
				if (byte_in == ppp_pkg::PRE1) begin
					phase_n = PH_PRE2;
				end else begin
					phase_n = PH_HUNT;
					result.status = ppp_pkg::ST_PRE1;
				end
			end
			PH_PRE2: begin
				if (byte_in == ppp_pkg::PRE2) begin
					phase_n = PH_PRE3;
				end else begin
					phase_n = PH_HUNT;
					result.status = ppp_pkg::ST_PRE2;
				end
			end
			PH_PRE3: begin
				if (byte_in == ppp_pkg::PRE3) begin
					phase_n = PH_SUM;
				end else begin
					phase_n = PH_HUNT;
					result.status = ppp_pkg::ST_PRE3;
				end
			end
			PH_SUM: begin
				phase_n = PH_LEN;
			end
			PH_LEN: begin
				if (byte_in < ppp_pkg::MIN_LENGTH) begin
					phase_n = PH_HUNT;
					result.status = ppp_pkg::ST_LEN;
				end else begin
					count_n = byte_in - ppp_pkg::HEADER_LEN;
					pos_n   = '0;
					phase_n = PH_DATA;
				end
			end
			PH_DATA: begin
				result.payload_valid = 1'b1;
				result.payload_byte  = byte_in;
				result.payload_index = pos_q;
				pos_n = pos_q + 8'd1;
				if (pos_n >= count_q) begin
					result.packet_last = 1'b1;
					if (xor_n != 8'h00) begin
						result.status = ppp_pkg::ST_SUM;
						phase_n = PH_HUNT;
					end else begin
						result.status = ppp_pkg::ST_OK;
						phase_n = PH_PRE1;
					end
				end
			end
			default: begin
				// hunt: restart the checksum as if 0x03 had just arrived
				phase_n = (byte_in == ppp_pkg::PRE1) ? PH_PRE2 : PH_HUNT;
				xor_n   = ppp_pkg::PRE1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE1;
			xor_q   <= '0;
			count_q <= '0;
			pos_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			xor_q   <= xor_n;
			count_q <= count_n;
			pos_q   <= pos_n;
		end
	end

endmodule

>>> rtl/core/ppp_out_stage.sv
// ---------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module ppp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ppp_pkg::result_t result,
	output logic             room,      // can load this cycle
	output logic             out_valid,
	input  logic             out_ready,
	output ppp_pkg::result_t result_s2
);

	assign room = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

endmodule

>>> rtl/core/preamble_packet_parser_core.sv
// An accepted byte is held in the input register, then parsed into the result register.
// Throughput: one byte per cycle while the result side is not stalling; the parse step sits
// alone between input and result register.
// Reset (arst_n low): phase back to first preamble byte, checksum and counters zeroed.
// ---------------------------------------------------------------------------
// Preamble packet parser, top level
// Byte stream in, one result per byte out. Packet framing:
//   0x03 0xAF 0xEF, checksum byte, total length L (L >= HEADER_BYTES + 1),
//   then L - HEADER_BYTES payload bytes; XOR over the whole packet is zero.
// Any framing or checksum error drops into hunt, which waits for 0x03.
// ---------------------------------------------------------------------------
module preamble_packet_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index
	output logic        m_axis_tlast,   // packet_last
	output logic [3:0]  m_axis_tuser    // [0] payload_valid, [3:1] status
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             room;
	logic             advance;
	ppp_pkg::result_t result;
	ppp_pkg::result_t result_s2;

	// the held byte moves through the parse step whenever the result
	// register is empty or being drained in the same cycle
	assign advance = valid_s1 && room;

	ppp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.take     (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// framing state only advances on a consumed byte
	ppp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.result  (result)
	);

	ppp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result_s2 (result_s2)
	);

	assign m_axis_tdata = {result_s2.payload_index, result_s2.payload_byte};
	assign m_axis_tlast = result_s2.packet_last;
	assign m_axis_tuser = {result_s2.status, result_s2.payload_valid};

endmodule

>>> rtl/core/ppp_checker.sv
// ---------------------------------------------------------------------------
// Preamble packet parser port checker
// Watches the result stream for field combinations the parser cannot emit.
// ---------------------------------------------------------------------------
`include "preamble_packet_parser_core_defines.svh"

module ppp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [3:0]  m_axis_tuser
);

	logic       pay_valid;
	logic [2:0] stat;
	logic       end_status;
	logic [20:0] res_bits;

	assign pay_valid  = m_axis_tuser[0];
	assign stat       = m_axis_tuser[3:1];
	assign end_status = (stat == ppp_pkg::ST_OK) || (stat == ppp_pkg::ST_SUM);
	assign res_bits   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

	// non-payload results carry zero data and never close a packet
	`PPP_ASSERT_NOW(a_idle_fields_zero, m_axis_tvalid && !pay_valid, m_axis_tdata == '0 && !m_axis_tlast)

	// packet end reports ok or checksum error, nothing else
	`PPP_ASSERT_NOW(a_last_status, m_axis_tvalid && m_axis_tlast, pay_valid && end_status)

	// mid-packet payload bytes report no status
	`PPP_ASSERT_NOW(a_mid_status, m_axis_tvalid && pay_valid && !m_axis_tlast, stat == ppp_pkg::ST_NONE)

	// a stalled result holds
	`PPP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(res_bits))

endmodule

bind preamble_packet_parser_core ppp_checker u_ppp_checker (.*);

>>> dv/testbench.sv
// ---------------------------------------------------------------------------
// Preamble packet parser testbench
// Feeds the byte stream through a directed table and then randomly built
// packets: good, corrupt checksum, broken preamble, short length and noise.
// Random gaps on both sides. Every result transaction is checked field by
// field against a local framing predictor or the directed table's expected result.
// ---------------------------------------------------------------------------
module testbench;
	import ppp_pkg::*;

	typedef enum logic [3:0] {
		FR_SYNC1, FR_SYNC2, FR_SYNC3, FR_CSUM, FR_LEN, FR_BODY, FR_HUNT
	} frame_phase_t;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		result_t    r;
	} dir_row_t;

	localparam int RANDOM_BYTES = 1250;
	localparam int CYCLE_LIMIT  = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [3:0]  m_axis_tuser;

	// predictor state
	frame_phase_t fr_phase = FR_SYNC1;
	logic [7:0]   fr_xor = '0;
	logic [7:0]   fr_body_len = '0;
	logic [7:0]   fr_body_pos = '0;

	result_t  pending_results[$];
	dir_row_t dir_rows[$];
	int       mismatches = 0;
	int       cycles = 0;
	int       sent = 0;
	bit       quiet = 1'b0;

	preamble_packet_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// One framing step per accepted byte; hunt reseeds the XOR with the sync byte.
	function automatic result_t parse_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		r.status = ST_NONE;
		fr_xor = fr_xor ^ b;
		case (fr_phase)
			FR_SYNC1: begin
				if (b == PRE1) fr_phase = FR_SYNC2;
				else begin
					fr_phase = FR_HUNT;
					r.status = ST_PRE1;
				end
			end
			FR_SYNC2: begin
				if (b == PRE2) fr_phase = FR_SYNC3;
				else begin
					fr_phase = FR_HUNT;
					r.status = ST_PRE2;
				end
			end
			FR_SYNC3: begin
				if (b == PRE3) fr_phase = FR_CSUM;
				else begin
					fr_phase = FR_HUNT;
					r.status = ST_PRE3;
				end
			end
			FR_CSUM: fr_phase = FR_LEN;
			FR_LEN: begin
				if (b < MIN_LENGTH) begin
					fr_phase = FR_HUNT;
					r.status = ST_LEN;
				end else begin
					fr_body_len = b - HEADER_LEN;
					fr_body_pos = '0;
					fr_phase = FR_BODY;
				end
			end
			FR_BODY: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				r.payload_index = fr_body_pos;
				fr_body_pos = fr_body_pos + 8'd1;
				if (fr_body_pos >= fr_body_len) begin
					r.packet_last = 1'b1;
					if (fr_xor != 8'd0) begin
						r.status = ST_SUM;
						fr_phase = FR_HUNT;
					end else begin
						r.status = ST_OK;
						fr_phase = FR_SYNC1;
					end
				end
			end
			default: begin
				fr_phase = (b == PRE1) ? FR_SYNC2 : FR_HUNT;
				fr_xor = PRE1;
			end
		endcase
		return r;
	endfunction

	function automatic result_t err_only(input status_t s);
		result_t r;
		r = '0;
		r.status = s;
		return r;
	endfunction

	function automatic logic [7:0] sync_byte(input int k);
		case (k)
			0: return PRE1;
			1: return PRE2;
			default: return PRE3;
		endcase
	endfunction

	// mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Drive one byte; returns at the edge of its transaction.
	task automatic drive_byte(input logic [7:0] b, input bit typed = 1'b0,
			input result_t fixed = '0);
		int      gap;
		bit      taken;
		result_t r;
		gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
		r = parse_byte(b);
		pending_results.push_back(typed ? fixed : r);
		sent++;
	endtask

	task automatic send_preamble(input int count);
		for (int k = 0; k < count; k++) drive_byte(sync_byte(k));
	endtask

	task automatic send_packet();
		logic [7:0] body[$];
		logic [7:0] len, csum, bad;
		int         kind, n, k;
		kind = $urandom_range(0, 99);
		quiet = ($urandom_range(0, 9) == 0);
		if (kind < 5) begin
			// line noise, biased toward the sync byte
			n = $urandom_range(1, 6);
			repeat (n) drive_byte(($urandom_range(0, 3) == 0) ? PRE1 : 8'($urandom));
		end else if (kind < 13) begin
			k = $urandom_range(0, 2);
			send_preamble(k);
			bad = 8'($urandom);
			if (bad == sync_byte(k)) bad = bad ^ 8'($urandom_range(1, 255));
			drive_byte(bad);
		end else if (kind < 20) begin
			send_preamble(3);
			drive_byte(8'($urandom));
			drive_byte(8'($urandom_range(0, HEADER_BYTES)));
		end else begin
			if ($urandom_range(0, 29) == 0)
				n = $urandom_range(0, 1) ? 250 : $urandom_range(100, 249);
			else
				n = $urandom_range(1, 12);
			len = 8'(n + HEADER_BYTES);
			csum = PRE1 ^ PRE2 ^ PRE3 ^ len;
			for (int i = 0; i < n; i++) begin
				body.push_back(8'($urandom));
				csum = csum ^ body[i];
			end
			if (kind < 32) csum = csum ^ 8'($urandom_range(1, 255));
			send_preamble(3);
			drive_byte(csum);
			drive_byte(len);
			foreach (body[i]) drive_byte(body[i]);
		end
	endtask

	// result side backpressure
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) stall = idle_len();
			end
		end
	end

	// Result transactions: outputs are stable from the falling edge to the accepting edge.
	initial begin
		result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no byte outstanding");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("payload_valid", want.payload_valid, m_axis_tuser[0]);
					check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
					check_field("payload_index", want.payload_index, m_axis_tdata[15:8]);
					check_field("packet_last", want.packet_last, m_axis_tlast);
					check_field("status", want.status, m_axis_tuser[3:1]);
				end
			end
		end
	end

	initial begin
		// Directed table: framing errors from each preamble phase, short length,
		// a one-byte good packet and a one-byte checksum failure.
		dir_rows.push_back('{8'h00, 1'b1, err_only(ST_PRE1)});
		dir_rows.push_back('{PRE1, 1'b0, '0});                 // hunt finds sync
		dir_rows.push_back('{8'h00, 1'b1, err_only(ST_PRE2)});
		dir_rows.push_back('{PRE1, 1'b0, '0});
		dir_rows.push_back('{PRE2, 1'b0, '0});
		dir_rows.push_back('{8'hFF, 1'b1, err_only(ST_PRE3)});
		dir_rows.push_back('{PRE1, 1'b0, '0});
		dir_rows.push_back('{PRE2, 1'b0, '0});
		dir_rows.push_back('{PRE3, 1'b0, '0});
		dir_rows.push_back('{8'h00, 1'b0, '0});
		dir_rows.push_back('{8'h00, 1'b1, err_only(ST_LEN)});  // length zero
		dir_rows.push_back('{PRE1, 1'b0, '0});
		dir_rows.push_back('{PRE2, 1'b0, '0});
		dir_rows.push_back('{PRE3, 1'b0, '0});
		dir_rows.push_back('{8'hBA, 1'b0, '0});                // XOR closes to zero
		dir_rows.push_back('{MIN_LENGTH, 1'b0, '0});
		dir_rows.push_back('{8'hFF, 1'b1, '{1'b1, 8'hFF, 8'h00, 1'b1, ST_OK}});
		dir_rows.push_back('{PRE1, 1'b0, '0});
		dir_rows.push_back('{PRE2, 1'b0, '0});
		dir_rows.push_back('{PRE3, 1'b0, '0});
		dir_rows.push_back('{8'h00, 1'b0, '0});
		dir_rows.push_back('{MIN_LENGTH, 1'b0, '0});
		dir_rows.push_back('{8'h00, 1'b1, '{1'b1, 8'h00, 8'h00, 1'b1, ST_SUM}});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) drive_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].r);
		while (sent < dir_rows.size() + RANDOM_BYTES) send_packet();
		s_axis_tvalid <= 1'b0;
		quiet = 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ppp_pkg.sv
rtl/core/ppp_in_stage.sv
rtl/core/ppp_parse.sv
rtl/core/ppp_out_stage.sv
rtl/core/preamble_packet_parser_core.sv
rtl/core/ppp_checker.sv
dv/testbench.sv
